// ===== hdl/cor_pkg.sv =====
package cor_pkg;

   localparam int POINT_W = 14;
   localparam int COLOR_W = 24;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } command_type;

endpackage

// ===== hdl/cor_channels.sv =====
interface cor_req_if #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
);
   import cor_pkg::*;

   logic                   valid;
   logic                   ready;
   command_type            command;
   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;
   logic [RADIUS_BITS-1:0] radius;
   logic [COLOR_W-1:0]     pixel_color;

   modport source (
      output valid, command, center_x, center_y, radius, pixel_color,
      input  ready
   );

   modport sink (
      input  valid, command, center_x, center_y, radius, pixel_color,
      output ready
   );
endinterface

interface cor_rsp_if;
   import cor_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;
   logic [COLOR_W-1:0]        point_color;
   logic                      last_of_step;
   logic                      circle_done;

   modport source (
      output valid, point_x, point_y, point_color, last_of_step, circle_done,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, point_color, last_of_step, circle_done,
      output ready
   );
endinterface

// ===== hdl/cor_front.sv =====
module cor_front #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   cor_req_if.sink                       req_ch,
   input  logic                          job_space,
   output logic                          job_push,
   output logic [COORD_BITS-1:0]         job_cx,
   output logic [COORD_BITS-1:0]         job_cy,
   output logic signed [RADIUS_BITS+1:0] job_x,
   output logic signed [RADIUS_BITS+1:0] job_y,
   output logic [cor_pkg::COLOR_W-1:0]   job_color,
   output logic                          job_done
);
   import cor_pkg::*;

   localparam int XW = RADIUS_BITS + 2;
   localparam int EW = RADIUS_BITS + 4;

   logic                  busy_ff, busy_in;
   logic signed [XW-1:0]  x_ff, x_in;
   logic signed [XW-1:0]  y_ff, y_in;
   logic signed [EW-1:0]  err_ff, err_in;
   logic [COORD_BITS-1:0] cx_ff, cx_in;
   logic [COORD_BITS-1:0] cy_ff, cy_in;
   logic [COLOR_W-1:0]    color_ff, color_in;

   logic                 accept;
   logic                 take_y;
   logic                 take_x;
   logic signed [EW-1:0] x_e, y_e, y1, e1, x1, e2, r_e;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = job_space;

   always_comb begin
      x_e    = EW'(x_ff);
      y_e    = EW'(y_ff);
      take_y = (err_ff <= y_e);
      y1     = take_y ? y_e + EW'(1) : y_e;
      e1     = take_y ? err_ff + (y1 <<< 1) + EW'(1) : err_ff;
      take_x = (err_ff > x_e) || (e1 > y1);
      x1     = take_x ? x_e + EW'(1) : x_e;
      e2     = take_x ? e1 + (x1 <<< 1) + EW'(1) : e1;
      r_e    = signed'(EW'({1'b0, req_ch.radius}));
   end

   assign job_push  = accept && (req_ch.command == CMD_STEP) && busy_ff;
   assign job_cx    = cx_ff;
   assign job_cy    = cy_ff;
   assign job_x     = x_ff;
   assign job_y     = y_ff;
   assign job_color = color_ff;
   assign job_done  = !x1[EW-1];

   always_comb begin
      busy_in  = busy_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      err_in   = err_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      if (accept && (req_ch.command == CMD_START)) begin
         busy_in  = 1'b1;
         x_in     = XW'(-r_e);
         y_in     = '0;
         err_in   = EW'(2) - (r_e <<< 1);
         cx_in    = req_ch.center_x;
         cy_in    = req_ch.center_y;
         color_in = req_ch.pixel_color;
      end else if (job_push) begin
         busy_in = x1[EW-1];
         x_in    = XW'(x1);
         y_in    = XW'(y1);
         err_in  = e2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         x_ff     <= '0;
         y_ff     <= '0;
         err_ff   <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         color_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         err_ff   <= err_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         color_ff <= color_in;
      end
   end

endmodule

// ===== hdl/cor_queue.sv =====
module cor_queue #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             space,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             avail
);
   localparam int DEPTH   = 2;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign space    = (count_ff != COUNT_W'(DEPTH));
   assign avail    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_W'(push) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/cor_back.sv =====
module cor_back #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_avail,
   output logic                          job_pop,
   input  logic [COORD_BITS-1:0]         job_cx,
   input  logic [COORD_BITS-1:0]         job_cy,
   input  logic signed [RADIUS_BITS+1:0] job_x,
   input  logic signed [RADIUS_BITS+1:0] job_y,
   input  logic [cor_pkg::COLOR_W-1:0]   job_color,
   input  logic                          job_done,
   cor_rsp_if.source                     rsp_ch
);
   import cor_pkg::*;

   localparam int XW = RADIUS_BITS + 2;
   localparam int SW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quadrant_type;

   logic                      active_ff, active_in;
   quadrant_type              quad_ff, quad_in;
   logic [COORD_BITS-1:0]     cx_ff, cx_in;
   logic [COORD_BITS-1:0]     cy_ff, cy_in;
   logic signed [XW-1:0]      x_ff, x_in;
   logic signed [XW-1:0]      y_ff, y_in;
   logic [COLOR_W-1:0]        color_ff, color_in;
   logic                      done_ff, done_in;

   logic                      valid_ff, valid_in;
   logic signed [POINT_W-1:0] px_ff, px_in;
   logic signed [POINT_W-1:0] py_ff, py_in;
   logic [COLOR_W-1:0]        pcolor_ff, pcolor_in;
   logic                      last_ff, last_in;
   logic                      cdone_ff, cdone_in;

   logic                 advance;
   logic                 job_end;
   logic signed [SW-1:0] cxs, cys, xs, ys, dx, dy, px, py;

   assign advance = !valid_ff || rsp_ch.ready;
   assign job_end = !active_ff || (quad_ff == QUAD_3);
   assign job_pop = job_avail && advance && job_end;

   always_comb begin
      cxs = SW'(signed'({1'b0, cx_ff}));
      cys = SW'(signed'({1'b0, cy_ff}));
      xs  = SW'(x_ff);
      ys  = SW'(y_ff);
      case (quad_ff)
         QUAD_0: begin
            dx = -xs;
            dy = ys;
         end
         QUAD_1: begin
            dx = -ys;
            dy = -xs;
         end
         QUAD_2: begin
            dx = xs;
            dy = -ys;
         end
         QUAD_3: begin
            dx = ys;
            dy = xs;
         end
         default: begin
            dx = '0;
            dy = '0;
         end
      endcase
      px = cxs + dx;
      py = cys + dy;
   end

   always_comb begin
      active_in = active_ff;
      quad_in   = quad_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      color_in  = color_ff;
      done_in   = done_ff;
      valid_in  = valid_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      pcolor_in = pcolor_ff;
      last_in   = last_ff;
      cdone_in  = cdone_ff;
      if (advance) begin
         valid_in  = active_ff;
         px_in     = POINT_W'(px);
         py_in     = POINT_W'(py);
         pcolor_in = color_ff;
         last_in   = (quad_ff == QUAD_3);
         cdone_in  = (quad_ff == QUAD_3) && done_ff;
         if (job_end) begin
            active_in = job_avail;
            quad_in   = QUAD_0;
            cx_in     = job_cx;
            cy_in     = job_cy;
            x_in      = job_x;
            y_in      = job_y;
            color_in  = job_color;
            done_in   = job_done;
         end else begin
            quad_in = quadrant_type'(quad_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         quad_ff   <= QUAD_0;
         valid_ff  <= 1'b0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         color_ff  <= '0;
         done_ff   <= 1'b0;
         px_ff     <= '0;
         py_ff     <= '0;
         pcolor_ff <= '0;
         last_ff   <= 1'b0;
         cdone_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         quad_ff   <= quad_in;
         valid_ff  <= valid_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         color_ff  <= color_in;
         done_ff   <= done_in;
         px_ff     <= px_in;
         py_ff     <= py_in;
         pcolor_ff <= pcolor_in;
         last_ff   <= last_in;
         cdone_ff  <= cdone_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.point_x      = px_ff;
   assign rsp_ch.point_y      = py_ff;
   assign rsp_ch.point_color  = pcolor_ff;
   assign rsp_ch.last_of_step = last_ff;
   assign rsp_ch.circle_done  = cdone_ff;

endmodule

// ===== hdl/circle_outline_rasterizer.sv =====
// Channel   Direction  Handshake               Carries
// req_ch    in         req_ch.valid/ready      start or step request
// rsp_ch    out        rsp_ch.valid/ready      one outline pixel
//
// A start request gives no pixel; a step request gives four pixels, one per cycle
// while rsp_ch is ready, as the back end walks the four quadrants, taking the
// next step from the queue on the last one. A step request is written into a
// two-entry queue at the edge that accepts it; with the back end idle it passes
// the back end's job and then output registers before its first pixel is shown.
// Reset is synchronous and clears all control state. A stalled rsp_ch fills the
// queue and then holds req_ch.ready low.
module circle_outline_rasterizer #(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic      clock,
   input  logic      reset,
   cor_req_if.sink   req_ch,
   cor_rsp_if.source rsp_ch
);
   import cor_pkg::*;

   localparam int XW    = RADIUS_BITS + 2;
   localparam int JOB_W = 2 * COORD_BITS + 2 * XW + COLOR_W + 1;

   logic                  q_space, q_avail, q_push, q_pop;
   logic [JOB_W-1:0]      push_data, pop_data;

   logic [COORD_BITS-1:0] f_cx, f_cy, b_cx, b_cy;
   logic signed [XW-1:0]  f_x, f_y, b_x, b_y;
   logic [COLOR_W-1:0]    f_color, b_color;
   logic                  f_done, b_done;

   cor_front #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .job_space (q_space),
      .job_push  (q_push),
      .job_cx    (f_cx),
      .job_cy    (f_cy),
      .job_x     (f_x),
      .job_y     (f_y),
      .job_color (f_color),
      .job_done  (f_done)
   );

   assign push_data = {f_cx, f_cy, f_x, f_y, f_color, f_done};

   cor_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .space     (q_space),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .avail     (q_avail)
   );

   assign {b_cx, b_cy, b_x, b_y, b_color, b_done} = pop_data;

   cor_back #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_avail (q_avail),
      .job_pop   (q_pop),
      .job_cx    (b_cx),
      .job_cy    (b_cy),
      .job_x     (b_x),
      .job_y     (b_y),
      .job_color (b_color),
      .job_done  (b_done),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== hdl/cor_checker.sv =====
module cor_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [cor_pkg::POINT_W-1:0] rsp_point_x,
   input logic signed [cor_pkg::POINT_W-1:0] rsp_point_y,
   input logic [cor_pkg::COLOR_W-1:0]        rsp_point_color,
   input logic                               rsp_last_of_step,
   input logic                               rsp_circle_done
);
   import cor_pkg::*;

   localparam logic [1:0] LAST_SLOT = 2'd3;

   logic [1:0] slot_ff, slot_in;

   assign slot_in = (rsp_valid && rsp_ready) ? slot_ff + 2'd1 : slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pixel withdrawn while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_point_x) && $stable(rsp_point_y)
         && $stable(rsp_point_color) && $stable(rsp_last_of_step)
         && $stable(rsp_circle_done))
      else $error("pixel changed while stalled");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_circle_done |-> rsp_last_of_step)
      else $error("circle finished away from the end of a step");

   a_step_of_four: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> (rsp_last_of_step == (slot_ff == LAST_SLOT)))
      else $error("step did not give exactly four pixels");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel shown straight after reset");

endmodule

bind circle_outline_rasterizer cor_checker u_cor_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_point_x      (rsp_ch.point_x),
   .rsp_point_y      (rsp_ch.point_y),
   .rsp_point_color  (rsp_ch.point_color),
   .rsp_last_of_step (rsp_ch.last_of_step),
   .rsp_circle_done  (rsp_ch.circle_done)
);
